// ===== hw/rtl/qxm_pkg.sv =====
package qxm_pkg;

   // Fixed geometry of the mixer.
   localparam int MOTOR_COUNT   = 4;
   localparam int DUTY_BITS_DEF = 16;
   localparam int DUTY_W        = 16;
   localparam int STAMP_W       = 32;

   // Configuration register indexes.
   localparam logic [2:0] REG_ARM_LENGTH    = 3'd0;
   localparam logic [2:0] REG_TORQUE_RATIO  = 3'd1;
   localparam logic [2:0] REG_THRUST_COEF   = 3'd2;
   localparam logic [2:0] REG_CURVE_SQUARE  = 3'd3;
   localparam logic [2:0] REG_CURVE_LINEAR  = 3'd4;
   localparam logic [2:0] REG_CURVE_OFFSET  = 3'd5;
   localparam logic [2:0] REG_BATT_FLOOR    = 3'd6;
   localparam logic [2:0] REG_BATT_NOMINAL  = 3'd7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 27;

   // Register reset values.
   localparam logic [18:0] ARM_LENGTH_RST   = 19'd23000;
   localparam logic [16:0] TORQUE_RATIO_RST = 17'd4100;
   localparam logic [19:0] THRUST_COEF_RST  = 20'd10000;
   localparam logic [26:0] CURVE_SQUARE_RST = 27'd6036800;
   localparam logic [26:0] CURVE_LINEAR_RST = 27'd6699042;
   localparam logic [19:0] CURVE_OFFSET_RST = 20'd15300;
   localparam logic [12:0] BATT_FLOOR_RST   = 13'd2500;
   localparam logic [12:0] BATT_NOMINAL_RST = 13'd3700;

   // Action codes of an input word.
   localparam logic [1:0] ACT_MIX    = 2'd0;
   localparam logic [1:0] ACT_ARM    = 2'd1;
   localparam logic [1:0] ACT_DISARM = 2'd2;
   localparam logic [1:0] ACT_TEST   = 2'd3;

   // Datapath widths.
   localparam int NUM_W = 62;   // signed mixed numerator
   localparam int DVD_W = 64;   // divider dividend
   localparam int DVS_W = 38;   // divider divisor (4*d*k is the widest)
   localparam int LIM_W = 23;   // battery limit in microvolts
   localparam int CAP_W = 50;   // limit times 10^8

   // Negated terms per motor: bit 0 roll, bit 1 pitch, bit 2 yaw.
   // Motor order: front right, rear right, rear left, front left.
   localparam logic [2:0] MIX_NEG [MOTOR_COUNT] = '{3'b001, 3'b111, 3'b010, 3'b100};

   // Start command to one lane.
   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
   } lane_cmd_type;

   // Settings shared by all lanes for one command.
   typedef struct packed {
      logic [DVS_W-1:0] dk4;
      logic [19:0]      ct;
      logic [26:0]      am;
      logic [26:0]      bm;
      logic [19:0]      cm;
      logic [LIM_W-1:0] lim;
      logic [CAP_W-1:0] cap;
   } lane_cfg_type;

   // Status of one lane.
   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DUTY_W-1:0] duty;
   } lane_res_type;

endpackage

// ===== hw/rtl/qxm_req_if.sv =====
interface qxm_req_if;
   import qxm_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [22:0] total_thrust_un;
   logic signed [27:0] roll_torque_nnm;
   logic signed [27:0] pitch_torque_nnm;
   logic signed [27:0] yaw_torque_nnm;
   logic [12:0]        battery_mv;
   logic [15:0]        test_duty_fr;
   logic [15:0]        test_duty_rr;
   logic [15:0]        test_duty_rl;
   logic [15:0]        test_duty_fl;
   logic [STAMP_W-1:0] stamp_in;

   modport source (
      output valid, action, total_thrust_un, roll_torque_nnm, pitch_torque_nnm,
         yaw_torque_nnm, battery_mv, test_duty_fr, test_duty_rr, test_duty_rl,
         test_duty_fl, stamp_in,
      input  ready
   );

   modport sink (
      input  valid, action, total_thrust_un, roll_torque_nnm, pitch_torque_nnm,
         yaw_torque_nnm, battery_mv, test_duty_fr, test_duty_rr, test_duty_rl,
         test_duty_fl, stamp_in,
      output ready
   );

endinterface

// ===== hw/rtl/qxm_rsp_if.sv =====
interface qxm_rsp_if;
   import qxm_pkg::*;

   logic               valid;
   logic               ready;
   logic [DUTY_W-1:0]  duty_fr;
   logic [DUTY_W-1:0]  duty_rr;
   logic [DUTY_W-1:0]  duty_rl;
   logic [DUTY_W-1:0]  duty_fl;
   logic [STAMP_W-1:0] stamp_out;
   logic               motors_enabled;

   modport source (
      output valid, duty_fr, duty_rr, duty_rl, duty_fl, stamp_out, motors_enabled,
      input  ready
   );

   modport sink (
      input  valid, duty_fr, duty_rr, duty_rl, duty_fl, stamp_out, motors_enabled,
      output ready
   );

endinterface

// ===== hw/rtl/qxm_div.sv =====
module qxm_div import qxm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEPS = DVD_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DVS_W:0]   trial;

   // Two restoring quotient bits per cycle.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < 2; i++) begin
         trial  = {rem_in, quo_in[DVD_W-1]};
         quo_in = {quo_in[DVD_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial     = trial - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[DVS_W-1:0];
      end
   end

   // Control: step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: dividend shifts out as the quotient shifts in.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/qxm_sqrt.sv =====
module qxm_sqrt import qxm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DVD_W-1:0]   radicand,
   output logic               done,
   output logic [DVD_W/2-1:0] root
);

   localparam int STEPS  = DVD_W / 2;
   localparam int CNT_W  = $clog2(STEPS);
   localparam int ROOT_W = DVD_W / 2;

   logic [DVD_W-1:0]  rad_ff;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, done_ff;
   logic [ROOT_W+3:0] part, trial;

   // One root bit per cycle, two radicand bits brought down.
   always_comb begin
      part  = {rem_ff, rad_ff[DVD_W-1:DVD_W-2]};
      trial = {2'b00, root_ff, 2'b01};
      if (part >= trial) begin
         rem_in  = (ROOT_W+2)'(part - trial);
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = part[ROOT_W+1:0];
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   // Control: step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[DVD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== hw/rtl/qxm_lane.sv =====
module qxm_lane import qxm_pkg::*; #(
   parameter int DUTY_BITS = DUTY_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  lane_cmd_type cmd,
   input  lane_cfg_type cfg,
   output lane_res_type res
);

   localparam logic [DUTY_W-1:0] FULL = DUTY_W'((17'd1 << DUTY_BITS) - 17'd1);
   localparam logic [44:0]       T_MAX = 45'd1 << 44;

   localparam logic [3:0] L_IDLE = 4'd0;
   localparam logic [3:0] L_T    = 4'd1;
   localparam logic [3:0] L_TM   = 4'd2;
   localparam logic [3:0] L_W2   = 4'd3;
   localparam logic [3:0] L_SQ   = 4'd4;
   localparam logic [3:0] L_M1   = 4'd5;
   localparam logic [3:0] L_M2   = 4'd6;
   localparam logic [3:0] L_M3   = 4'd7;
   localparam logic [3:0] L_V    = 4'd8;
   localparam logic [3:0] L_VC   = 4'd9;
   localparam logic [3:0] L_D    = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic              done_ff, done_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;

   logic [44:0]      t_ff;
   logic [DVD_W-1:0] w2_ff;
   logic [31:0]      w_ff;
   logic [51:0]      pa_lo_ff, pa_hi_ff;
   logic [58:0]      pb_ff;
   logic             big_ff;
   logic [77:0]      a_ff;
   logic [72:0]      b_ff;
   logic [25:0]      v_ff;

   logic             div_go, div_done, sq_go, sq_done;
   logic [DVD_W-1:0] div_a, div_q;
   logic [DVS_W-1:0] div_b;
   logic [31:0]      sq_root;
   logic [DVD_W:0]   t_scaled;
   logic [78:0]      ab_sum;

   assign t_scaled = (DVD_W+1)'(t_ff) * (DVD_W+1)'(1000000);
   assign ab_sum   = {1'b0, a_ff} + 79'(b_ff);

   qxm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   qxm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_go),
      .radicand (div_q),
      .done     (sq_done),
      .root     (sq_root)
   );

   // Sequencer of one motor: thrust, speed, curve voltage, duty.
   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      duty_in  = duty_ff;
      div_go   = 1'b0;
      div_a    = '0;
      div_b    = '0;
      sq_go    = 1'b0;
      case (state_ff)
         L_IDLE: begin
            if (cmd.start) begin
               done_in = 1'b0;
               if (cmd.num[NUM_W-1] || cmd.num == '0) begin
                  duty_in = '0;
                  done_in = 1'b1;
               end else begin
                  div_go   = 1'b1;
                  div_a    = DVD_W'(unsigned'(cmd.num));
                  div_b    = cfg.dk4;
                  state_in = L_T;
               end
            end
         end
         L_T: begin
            if (div_done) begin
               if (div_q == '0) begin
                  duty_in  = '0;
                  done_in  = 1'b1;
                  state_in = L_IDLE;
               end else begin
                  state_in = L_TM;
               end
            end
         end
         L_TM: begin
            div_go   = 1'b1;
            div_a    = t_scaled[DVD_W-1:0];
            div_b    = DVS_W'(cfg.ct);
            state_in = L_W2;
         end
         L_W2: begin
            if (div_done) begin
               sq_go    = 1'b1;
               state_in = L_SQ;
            end
         end
         L_SQ: begin
            if (sq_done) begin
               state_in = L_M1;
            end
         end
         L_M1: begin
            state_in = L_M2;
         end
         L_M2: begin
            state_in = L_M3;
         end
         L_M3: begin
            if ((cfg.am != '0 && (big_ff || a_ff > 78'(cfg.cap))) || b_ff > 73'(cfg.cap)) begin
               duty_in  = FULL;
               done_in  = 1'b1;
               state_in = L_IDLE;
            end else begin
               div_go   = 1'b1;
               div_a    = ab_sum[DVD_W-1:0];
               div_b    = DVS_W'(100000000);
               state_in = L_V;
            end
         end
         L_V: begin
            if (div_done) begin
               state_in = L_VC;
            end
         end
         L_VC: begin
            if (v_ff >= 26'(cfg.lim)) begin
               duty_in  = FULL;
               done_in  = 1'b1;
               state_in = L_IDLE;
            end else begin
               div_go   = 1'b1;
               div_a    = DVD_W'(v_ff) << DUTY_BITS;
               div_b    = DVS_W'(cfg.lim);
               state_in = L_D;
            end
         end
         L_D: begin
            if (div_done) begin
               duty_in  = div_q[DUTY_W-1:0];
               done_in  = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Intermediate values of the motor model.
   always_ff @(posedge clock) begin
      duty_ff <= duty_in;
      if (state_ff == L_T && div_done) begin
         t_ff <= (div_q > DVD_W'(T_MAX)) ? T_MAX : div_q[44:0];
      end
      if (state_ff == L_W2 && div_done) begin
         w2_ff <= div_q;
      end
      if (state_ff == L_SQ && sq_done) begin
         w_ff <= sq_root;
      end
      if (state_ff == L_M1) begin
         pa_lo_ff <= 52'(cfg.am) * 52'(w2_ff[24:0]);
         pa_hi_ff <= 52'(cfg.am) * 52'(w2_ff[49:25]);
         pb_ff    <= 59'(cfg.bm) * 59'(w_ff);
         big_ff   <= w2_ff[DVD_W-1:50] != '0;
      end
      if (state_ff == L_M2) begin
         a_ff <= (78'(pa_hi_ff) << 25) + 78'(pa_lo_ff);
         b_ff <= 73'(pb_ff) * 73'(10000);
      end
      if (state_ff == L_V && div_done) begin
         v_ff <= div_q[25:0] + 26'(cfg.cm);
      end
   end

   assign res.busy = state_ff != L_IDLE;
   assign res.done = done_ff;
   assign res.duty = duty_ff;

endmodule

// ===== hw/rtl/quad_x_mixer_motor_duty.sv =====
// Arm words take effect on acceptance and publish nothing; a disarm word publishes a zero
// word if the block was armed; a test word goes through the pending and output registers.
// One word at a time: a mix word holds the block until every motor lane has run its chain
// of up to four divisions and one square root, and a word that publishes waits for ready.
// Reset (synchronous, active high) disarms the block, empties the result register and
// loads every configuration register with its default.
module quad_x_mixer_motor_duty import qxm_pkg::*; #(
   parameter int DUTY_BITS = DUTY_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   qxm_req_if.sink                req_bus,
   qxm_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam logic [DUTY_W-1:0] FULL = DUTY_W'((17'd1 << DUTY_BITS) - 17'd1);

   localparam logic [2:0] T_IDLE = 3'd0;
   localparam logic [2:0] T_P1   = 3'd1;
   localparam logic [2:0] T_P2   = 3'd2;
   localparam logic [2:0] T_P3   = 3'd3;
   localparam logic [2:0] T_P4   = 3'd4;
   localparam logic [2:0] T_RUN  = 3'd5;
   localparam logic [2:0] T_PUB  = 3'd6;

   // Configuration registers.
   logic [18:0] arm_length_ff;
   logic [16:0] torque_ratio_ff;
   logic [19:0] thrust_coef_ff;
   logic [26:0] curve_square_ff;
   logic [26:0] curve_linear_ff;
   logic [19:0] curve_offset_ff;
   logic [12:0] batt_floor_ff;
   logic [12:0] batt_nominal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_length_ff   <= ARM_LENGTH_RST;
         torque_ratio_ff <= TORQUE_RATIO_RST;
         thrust_coef_ff  <= THRUST_COEF_RST;
         curve_square_ff <= CURVE_SQUARE_RST;
         curve_linear_ff <= CURVE_LINEAR_RST;
         curve_offset_ff <= CURVE_OFFSET_RST;
         batt_floor_ff   <= BATT_FLOOR_RST;
         batt_nominal_ff <= BATT_NOMINAL_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_ARM_LENGTH:   arm_length_ff   <= csr_data[18:0];
            REG_TORQUE_RATIO: torque_ratio_ff <= csr_data[16:0];
            REG_THRUST_COEF:  thrust_coef_ff  <= csr_data[19:0];
            REG_CURVE_SQUARE: curve_square_ff <= csr_data;
            REG_CURVE_LINEAR: curve_linear_ff <= csr_data;
            REG_CURVE_OFFSET: curve_offset_ff <= csr_data[19:0];
            REG_BATT_FLOOR:   batt_floor_ff   <= csr_data[12:0];
            REG_BATT_NOMINAL: batt_nominal_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // Zero arm length, torque ratio and thrust coefficient count as one.
   logic [18:0] d_eff;
   logic [16:0] k_eff;
   logic [19:0] ct_eff;
   assign d_eff  = (arm_length_ff == '0) ? 19'd1 : arm_length_ff;
   assign k_eff  = (torque_ratio_ff == '0) ? 17'd1 : torque_ratio_ff;
   assign ct_eff = (thrust_coef_ff == '0) ? 20'd1 : thrust_coef_ff;

   logic [2:0] state_ff, state_in;
   logic       armed_ff, armed_in;
   logic       accept;
   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = state_ff == T_IDLE;

   // Captured command.
   logic signed [22:0] ut_ff;
   logic signed [27:0] roll_ff, pitch_ff, yaw_ff;
   logic [12:0]        vb_ff, vb_sel;
   logic [STAMP_W-1:0] stamp_ff;

   always_comb begin
      vb_sel = req_bus.battery_mv;
      if (vb_sel < batt_floor_ff) begin
         vb_sel = batt_nominal_ff;
      end
      if (vb_sel == '0) begin
         vb_sel = 13'd1;
      end
   end

   // First product stage.
   logic signed [42:0] pd_ff;
   logic signed [45:0] rk_ff, pk_ff;
   logic signed [47:0] yd_ff;
   logic [35:0]        dk_ff;
   logic [LIM_W-1:0]   lim_ff;
   // Second product stage.
   logic signed [NUM_W-1:0] nt_ff, np_ff, nq_ff, nr_ff;
   logic [CAP_W-1:0]        cap_ff;
   // Per-motor numerators.
   logic signed [NUM_W-1:0] n_ff [MOTOR_COUNT];
   logic signed [NUM_W-1:0] n_in [MOTOR_COUNT];

   // Mixing signs of the inverse X allocation.
   always_comb begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         n_in[m] = nt_ff + (MIX_NEG[m][0] ? -np_ff : np_ff)
                         + (MIX_NEG[m][1] ? -nq_ff : nq_ff)
                         + (MIX_NEG[m][2] ? -nr_ff : nr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ut_ff    <= req_bus.total_thrust_un;
         roll_ff  <= req_bus.roll_torque_nnm;
         pitch_ff <= req_bus.pitch_torque_nnm;
         yaw_ff   <= req_bus.yaw_torque_nnm;
         vb_ff    <= vb_sel;
         stamp_ff <= req_bus.stamp_in;
      end
      if (state_ff == T_P1) begin
         pd_ff  <= ut_ff * $signed({1'b0, d_eff});
         rk_ff  <= roll_ff * $signed({1'b0, k_eff});
         pk_ff  <= pitch_ff * $signed({1'b0, k_eff});
         yd_ff  <= yaw_ff * $signed({1'b0, d_eff});
         dk_ff  <= 36'(d_eff) * 36'(k_eff);
         lim_ff <= LIM_W'(vb_ff) * LIM_W'(1000);
      end
      if (state_ff == T_P2) begin
         nt_ff  <= NUM_W'(pd_ff * $signed({1'b0, k_eff}));
         np_ff  <= NUM_W'(rk_ff * $signed(11'd1000));
         nq_ff  <= NUM_W'(pk_ff * $signed(11'd1000));
         nr_ff  <= NUM_W'(yd_ff * $signed(11'd1000));
         cap_ff <= CAP_W'(lim_ff) * CAP_W'(100000000);
      end
      if (state_ff == T_P3) begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            n_ff[m] <= n_in[m];
         end
      end
   end

   // Motor lanes.
   lane_cfg_type lane_cfg;
   lane_cmd_type lane_cmd [MOTOR_COUNT];
   lane_res_type lane_res [MOTOR_COUNT];
   logic [MOTOR_COUNT-1:0] lane_done, lane_busy;

   assign lane_cfg.dk4 = {dk_ff, 2'b00};
   assign lane_cfg.ct  = ct_eff;
   assign lane_cfg.am  = curve_square_ff;
   assign lane_cfg.bm  = curve_linear_ff;
   assign lane_cfg.cm  = curve_offset_ff;
   assign lane_cfg.lim = lim_ff;
   assign lane_cfg.cap = cap_ff;

   for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
      assign lane_cmd[m].start = state_ff == T_P4;
      assign lane_cmd[m].num   = n_ff[m];
      assign lane_done[m]      = lane_res[m].done;
      assign lane_busy[m]      = lane_res[m].busy;

      qxm_lane #(
         .DUTY_BITS (DUTY_BITS)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .cmd   (lane_cmd[m]),
         .cfg   (lane_cfg),
         .res   (lane_res[m])
      );
   end

   // Pending result and the output register.
   logic [DUTY_W-1:0]  pend_duty_ff [MOTOR_COUNT];
   logic [STAMP_W-1:0] pend_stamp_ff;
   logic               pend_en_ff;
   logic               rsp_valid_ff, out_load;
   logic [DUTY_W-1:0]  out_duty_ff [MOTOR_COUNT];
   logic [STAMP_W-1:0] out_stamp_ff;
   logic               out_en_ff;
   logic [DUTY_W-1:0]  test_duty [MOTOR_COUNT];

   assign out_load = state_ff == T_PUB && (!rsp_valid_ff || rsp_bus.ready);
   assign test_duty[0] = req_bus.test_duty_fr;
   assign test_duty[1] = req_bus.test_duty_rr;
   assign test_duty[2] = req_bus.test_duty_rl;
   assign test_duty[3] = req_bus.test_duty_fl;

   // Control sequencer.
   always_comb begin
      state_in = state_ff;
      armed_in = armed_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               case (req_bus.action)
                  ACT_MIX: state_in = T_P1;
                  ACT_ARM: armed_in = 1'b1;
                  ACT_DISARM: begin
                     if (armed_ff) begin
                        armed_in = 1'b0;
                        state_in = T_PUB;
                     end
                  end
                  ACT_TEST: begin
                     armed_in = 1'b1;
                     state_in = T_PUB;
                  end
                  default: ;
               endcase
            end
         end
         T_P1: state_in = T_P2;
         T_P2: state_in = T_P3;
         T_P3: state_in = T_P4;
         T_P4: state_in = T_RUN;
         T_RUN: begin
            if (&lane_done && !(|lane_busy)) begin
               state_in = T_PUB;
            end
         end
         T_PUB: begin
            if (out_load) begin
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         armed_ff <= armed_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Merge stage: gather lane duties or the direct results.
   always_ff @(posedge clock) begin
      if (accept && req_bus.action == ACT_DISARM) begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            pend_duty_ff[m] <= '0;
         end
         pend_stamp_ff <= '0;
         pend_en_ff    <= 1'b0;
      end else if (accept && req_bus.action == ACT_TEST) begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            pend_duty_ff[m] <= (test_duty[m] > FULL) ? FULL : test_duty[m];
         end
         pend_stamp_ff <= req_bus.stamp_in;
         pend_en_ff    <= 1'b1;
      end else if (state_ff == T_RUN) begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            pend_duty_ff[m] <= lane_res[m].duty;
         end
         pend_stamp_ff <= stamp_ff;
         pend_en_ff    <= armed_ff;
      end
      if (out_load) begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            out_duty_ff[m] <= pend_duty_ff[m];
         end
         out_stamp_ff <= pend_stamp_ff;
         out_en_ff    <= pend_en_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.duty_fr        = out_duty_ff[0];
   assign rsp_bus.duty_rr        = out_duty_ff[1];
   assign rsp_bus.duty_rl        = out_duty_ff[2];
   assign rsp_bus.duty_fl        = out_duty_ff[3];
   assign rsp_bus.stamp_out      = out_stamp_ff;
   assign rsp_bus.motors_enabled = out_en_ff;

   // Arming and test words leave the block armed.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_bus.action == ACT_ARM || req_bus.action == ACT_TEST) |=> armed_ff)
      else $error("armed flag not set after arm or test word");

   // A disarm word always leaves the block disarmed.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.action == ACT_DISARM |=> !armed_ff)
      else $error("armed flag still set after disarm word");

   // Lanes are idle when a new command is launched.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == T_P4 |-> !(|lane_busy))
      else $error("lane started while still busy");

   // Published duties never exceed full scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_duty_ff[0] <= FULL && out_duty_ff[1] <= FULL
         && out_duty_ff[2] <= FULL && out_duty_ff[3] <= FULL))
      else $error("duty above full scale");

endmodule

// ===== test/qxm_duty_checker.sv =====
`timescale 1ns / 100ps

// Watches the command and duty channels of the mixer, keeps its own copy of
// the configuration and the armed flag, predicts every published word and
// compares it with what the block sends.
module qxm_duty_checker import qxm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   qxm_req_if                     req_bus,
   qxm_rsp_if                     rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending
);

   localparam longint unsigned FULL_DUTY = (64'd1 << DUTY_BITS_DEF) - 64'd1;

   typedef struct packed {
      logic [DUTY_W-1:0]  fr;
      logic [DUTY_W-1:0]  rr;
      logic [DUTY_W-1:0]  rl;
      logic [DUTY_W-1:0]  fl;
      logic [STAMP_W-1:0] stamp;
      logic               enabled;
   } duty_word_t;

   longint unsigned arm_um, kappa_um, ct_coef, sq_coef, lin_coef, offset_uv;
   longint unsigned floor_mv, nominal_mv;
   logic            armed;
   duty_word_t      duty_queue[$];

   assign pending = duty_queue.size();

   // Integer square root, rounded down.
   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Thrust numerator of one motor to its duty through the motor curve.
   function automatic logic [DUTY_W-1:0] motor_duty(longint n, longint unsigned dk4,
                                                    longint unsigned vb);
      longint unsigned ct, kb, t, w2, w, lim, cap, v;
      ct = (ct_coef != 0) ? ct_coef : 1;
      kb = lin_coef * 10000;
      if (n <= 0) return '0;
      t = longint'(n) / dk4;
      if (t == 0) return '0;
      if (t > (64'd1 << 44)) t = 64'd1 << 44;
      w2 = t * 1000000 / ct;
      w = root_floor(w2);
      lim = vb * 1000;
      cap = lim * 100000000;
      if (sq_coef != 0 && w2 > cap / sq_coef) return FULL_DUTY[DUTY_W-1:0];
      if (kb != 0 && w > cap / kb) return FULL_DUTY[DUTY_W-1:0];
      v = (sq_coef * w2 + kb * w) / 100000000 + offset_uv;
      if (v >= lim) return FULL_DUTY[DUTY_W-1:0];
      v = (v << DUTY_BITS_DEF) / lim;
      return v[DUTY_W-1:0];
   endfunction

   // Inverse X allocation of a mix command into four duties.
   function automatic duty_word_t mix_duties();
      duty_word_t      w;
      longint unsigned d, k, vb, dk4;
      longint          nt, np, nq, nr;
      d = (arm_um != 0) ? arm_um : 1;
      k = (kappa_um != 0) ? kappa_um : 1;
      vb = req_bus.battery_mv;
      if (vb < floor_mv) vb = nominal_mv;
      if (vb == 0) vb = 1;
      dk4 = 4 * d * k;
      nt = longint'($signed(req_bus.total_thrust_un)) * longint'(d) * longint'(k);
      np = longint'($signed(req_bus.roll_torque_nnm)) * 1000 * longint'(k);
      nq = longint'($signed(req_bus.pitch_torque_nnm)) * 1000 * longint'(k);
      nr = longint'($signed(req_bus.yaw_torque_nnm)) * 1000 * longint'(d);
      w.fr = motor_duty(nt - np + nq + nr, dk4, vb);
      w.rr = motor_duty(nt - np - nq - nr, dk4, vb);
      w.rl = motor_duty(nt + np - nq + nr, dk4, vb);
      w.fl = motor_duty(nt + np + nq - nr, dk4, vb);
      w.stamp = req_bus.stamp_in;
      w.enabled = armed;
      return w;
   endfunction

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      duty_word_t w;
      if (reset) begin
         arm_um     = ARM_LENGTH_RST;
         kappa_um   = TORQUE_RATIO_RST;
         ct_coef    = THRUST_COEF_RST;
         sq_coef    = CURVE_SQUARE_RST;
         lin_coef   = CURVE_LINEAR_RST;
         offset_uv  = CURVE_OFFSET_RST;
         floor_mv   = BATT_FLOOR_RST;
         nominal_mv = BATT_NOMINAL_RST;
         armed      = 1'b0;
         duty_queue.delete();
      end else begin
         // Register writes are only made while idle, so order does not matter.
         if (csr_we) begin
            case (csr_index)
               REG_ARM_LENGTH:   arm_um     = csr_data[18:0];
               REG_TORQUE_RATIO: kappa_um   = csr_data[16:0];
               REG_THRUST_COEF:  ct_coef    = csr_data[19:0];
               REG_CURVE_SQUARE: sq_coef    = csr_data[26:0];
               REG_CURVE_LINEAR: lin_coef   = csr_data[26:0];
               REG_CURVE_OFFSET: offset_uv  = csr_data[19:0];
               REG_BATT_FLOOR:   floor_mv   = csr_data[12:0];
               REG_BATT_NOMINAL: nominal_mv = csr_data[12:0];
               default: ;
            endcase
         end

         // Compare a published word with the oldest prediction.
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (duty_queue.size() == 0) begin
               $display("%0t: unexpected duty word, expected none, got stamp %0d",
                        $time, rsp_bus.stamp_out);
               fail_count++;
            end else begin
               w = duty_queue.pop_front();
               check_field("duty_fr", w.fr, rsp_bus.duty_fr);
               check_field("duty_rr", w.rr, rsp_bus.duty_rr);
               check_field("duty_rl", w.rl, rsp_bus.duty_rl);
               check_field("duty_fl", w.fl, rsp_bus.duty_fl);
               check_field("stamp_out", w.stamp, rsp_bus.stamp_out);
               check_field("motors_enabled", w.enabled, rsp_bus.motors_enabled);
            end
         end

         // Predict what an accepted command word causes.
         if (req_bus.valid && req_bus.ready) begin
            case (req_bus.action)
               ACT_ARM: armed = 1'b1;
               ACT_DISARM: begin
                  if (armed) begin
                     armed = 1'b0;
                     w = '0;
                     duty_queue.push_back(w);
                  end
               end
               ACT_TEST: begin
                  armed = 1'b1;
                  w.fr = req_bus.test_duty_fr;
                  w.rr = req_bus.test_duty_rr;
                  w.rl = req_bus.test_duty_rl;
                  w.fl = req_bus.test_duty_fl;
                  w.stamp = req_bus.stamp_in;
                  w.enabled = 1'b1;
                  duty_queue.push_back(w);
               end
               default: duty_queue.push_back(mix_duties());
            endcase
         end
      end
   end

endmodule

// ===== test/tb_quad_x_mixer_motor_duty.sv =====
`timescale 1ns / 100ps

module tb_quad_x_mixer_motor_duty;
   import qxm_pkg::*;

   typedef struct {
      logic [1:0]         action;
      logic signed [22:0] thrust;
      logic signed [27:0] roll;
      logic signed [27:0] pitch;
      logic signed [27:0] yaw;
      logic [12:0]        battery;
      logic [15:0]        duty[4];
      logic [31:0]        stamp;
   } command_t;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     fail_count;
   int                     pending;
   int                     idle_pct;
   int                     stall_pct;

   qxm_req_if req_bus ();
   qxm_rsp_if rsp_bus ();

   quad_x_mixer_motor_duty dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   qxm_duty_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   // Random back-pressure on the duty channel.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic command_t blank_command(logic [1:0] act);
      command_t c;
      c.action = act;
      c.thrust = '0;
      c.roll = '0;
      c.pitch = '0;
      c.yaw = '0;
      c.battery = 13'd3700;
      foreach (c.duty[i]) c.duty[i] = '0;
      c.stamp = $urandom;
      return c;
   endfunction

   function automatic command_t mix_command(int thrust, int roll, int pitch, int yaw,
                                            int battery);
      command_t c;
      c = blank_command(ACT_MIX);
      c.thrust = thrust;
      c.roll = roll;
      c.pitch = pitch;
      c.yaw = yaw;
      c.battery = battery;
      return c;
   endfunction

   // Torque of a chosen magnitude tier: small, in range, or any bit pattern.
   function automatic logic [27:0] random_torque();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5) return 28'($signed($urandom_range(0, 4000000)) - 2000000);
      if (sel < 8) return 28'($signed($urandom_range(0, 200000000)) - 100000000);
      return 28'($urandom);
   endfunction

   function automatic command_t random_command();
      command_t c;
      int       sel;
      sel = $urandom_range(99);
      c = blank_command(sel < 60 ? ACT_MIX : sel < 70 ? ACT_ARM :
                        sel < 82 ? ACT_DISARM : ACT_TEST);
      sel = $urandom_range(9);
      if (sel < 6) c.thrust = 23'($urandom_range(0, 1000000));
      else if (sel < 8) c.thrust = 23'($signed($urandom_range(0, 8000000)) - 4000000);
      else c.thrust = 23'($urandom);
      c.roll = random_torque();
      c.pitch = random_torque();
      c.yaw = random_torque();
      sel = $urandom_range(3);
      if (sel == 0) c.battery = 13'($urandom);
      else if (sel == 1) c.battery = 13'($urandom_range(2400, 2600));
      else c.battery = 13'($urandom_range(3000, 4200));
      foreach (c.duty[i]) c.duty[i] = 16'($urandom);
      return c;
   endfunction

   // Offers one word and returns at the edge that accepts it.
   task automatic send_command(command_t c);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.action           <= c.action;
      req_bus.total_thrust_un  <= c.thrust;
      req_bus.roll_torque_nnm  <= c.roll;
      req_bus.pitch_torque_nnm <= c.pitch;
      req_bus.yaw_torque_nnm   <= c.yaw;
      req_bus.battery_mv       <= c.battery;
      req_bus.test_duty_fr     <= c.duty[0];
      req_bus.test_duty_rr     <= c.duty[1];
      req_bus.test_duty_rl     <= c.duty[2];
      req_bus.test_duty_fl     <= c.duty[3];
      req_bus.stamp_in         <= c.stamp;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
   endtask

   // Waits for the last duty word, then idles on with no word offered before returning.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (220) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, longint unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   // Loads one of the register settings; each register gets a value every time.
   task automatic load_setting(int sel);
      longint unsigned v[8];
      case (sel)
         0: v = '{23000, 4100, 10000, 6036800, 6699042, 15300, 2500, 3700};
         1: v = '{500000, 100000, 1000000, 100000000, 100000000, 1000000, 6000, 6000};
         2: v = '{1000, 100, 1, 0, 0, 0, 0, 1000};
         3: v = '{0, 0, 0, 134217727, 0, 0, 0, 0};
         4: v = '{524287, 131071, 1048575, 134217727, 134217727, 1048575, 8191, 8191};
         default: v = '{$urandom_range(1000, 60000), $urandom_range(100, 20000),
                        $urandom_range(1, 100000), $urandom_range(0, 100000000),
                        $urandom_range(0, 100000000), $urandom_range(0, 1000000),
                        $urandom_range(0, 6000), $urandom_range(1000, 6000)};
      endcase
      write_reg(REG_ARM_LENGTH, v[0]);
      write_reg(REG_TORQUE_RATIO, v[1]);
      write_reg(REG_THRUST_COEF, v[2]);
      write_reg(REG_CURVE_SQUARE, v[3]);
      write_reg(REG_CURVE_LINEAR, v[4]);
      write_reg(REG_CURVE_OFFSET, v[5]);
      write_reg(REG_BATT_FLOOR, v[6]);
      write_reg(REG_BATT_NOMINAL, v[7]);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      command_t c;
      int       setting[8];
      setting = '{5, 1, 2, 3, 4, 5, 0, 5};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      rsp_bus.ready = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_MIX;
      req_bus.total_thrust_un = '0;
      req_bus.roll_torque_nnm = '0;
      req_bus.pitch_torque_nnm = '0;
      req_bus.yaw_torque_nnm = '0;
      req_bus.battery_mv = '0;
      req_bus.test_duty_fr = '0;
      req_bus.test_duty_rr = '0;
      req_bus.test_duty_rl = '0;
      req_bus.test_duty_fl = '0;
      req_bus.stamp_in = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset settings.
      send_command(mix_command(300000, 0, 0, 0, 3700));
      send_command(blank_command(ACT_DISARM));
      send_command(blank_command(ACT_ARM));
      send_command(mix_command(0, 0, 0, 0, 3700));
      send_command(mix_command(4000000, 0, 0, 0, 0));
      send_command(mix_command(-4000000, 0, 0, 0, 6000));
      send_command(mix_command(-4194304, -134217728, -134217728, -134217728, 8191));
      send_command(mix_command(4194303, 134217727, 134217727, 134217727, 2500));
      send_command(mix_command(400000, 100000000, 0, 0, 2499));
      send_command(mix_command(400000, 0, -100000000, 0, 3700));
      send_command(mix_command(400000, 0, 0, 100000000, 3700));
      send_command(mix_command(400000, 0, 0, -100000000, 3700));
      send_command(mix_command(3, 0, 0, 0, 3700));
      send_command(blank_command(ACT_DISARM));
      send_command(blank_command(ACT_DISARM));
      c = blank_command(ACT_TEST);
      foreach (c.duty[i]) c.duty[i] = 16'hFFFF;
      c.stamp = 32'hFFFF_FFFF;
      send_command(c);
      send_command(mix_command(200000, 50000, 50000, 20000, 4000));
      c = blank_command(ACT_TEST);
      c.stamp = '0;
      send_command(c);
      send_command(blank_command(ACT_DISARM));

      // Random phases under changing settings and idling patterns.
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         load_setting(setting[p]);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 88; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 88; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         if (p == 3) send_command(mix_command(0, 0, 0, 0, 0));
         repeat (80) send_command(random_command());
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== quad_x_mixer_motor_duty.f =====
hw/rtl/qxm_pkg.sv
hw/rtl/qxm_req_if.sv
hw/rtl/qxm_rsp_if.sv
hw/rtl/qxm_div.sv
hw/rtl/qxm_sqrt.sv
hw/rtl/qxm_lane.sv
hw/rtl/quad_x_mixer_motor_duty.sv
test/qxm_duty_checker.sv
test/tb_quad_x_mixer_motor_duty.sv
